@@ design/assert_macros.svh @@
// Assertion macros shared by the odometry RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define PDRO_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("invariant violated");

// Implication checked at every clock edge outside reset
`define PDRO_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication violated");

`endif

@@ design/pdro_pkg.sv @@
// Shared constants, tables and helpers for the planar odometry core
`timescale 1ns / 1ps
package pdro_pkg;

    localparam int DEF_CORDIC_STEPS = 16;
    localparam int DEF_FRAC_BITS    = 16;

    // CORDIC start value, Q30
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    // Microseconds per second
    localparam logic [20:0] MEGA = 21'd1000000;

    // Operation codes
    localparam logic OP_MOTION = 1'b0;
    localparam logic OP_RESET  = 1'b1;

    // Arctangent of 2^-i in 2^32-per-turn units
    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:    r = 32'd536870912;
            5'd1:    r = 32'd316933406;
            5'd2:    r = 32'd167458907;
            5'd3:    r = 32'd85004756;
            5'd4:    r = 32'd42667331;
            5'd5:    r = 32'd21354465;
            5'd6:    r = 32'd10679838;
            5'd7:    r = 32'd5340245;
            5'd8:    r = 32'd2670163;
            5'd9:    r = 32'd1335087;
            5'd10:   r = 32'd667544;
            5'd11:   r = 32'd333772;
            5'd12:   r = 32'd166886;
            5'd13:   r = 32'd83443;
            5'd14:   r = 32'd41722;
            5'd15:   r = 32'd20861;
            5'd16:   r = 32'd10430;
            5'd17:   r = 32'd5215;
            5'd18:   r = 32'd2608;
            5'd19:   r = 32'd1304;
            5'd20:   r = 32'd652;
            5'd21:   r = 32'd326;
            5'd22:   r = 32'd163;
            5'd23:   r = 32'd81;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    // Saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

@@ design/pdro_cordic.sv @@
// Iterative rotation-mode CORDIC: cosine and sine of a binary angle
`timescale 1ns / 1ps
module pdro_cordic #(
    parameter int STEPS = pdro_pkg::DEF_CORDIC_STEPS,
    parameter int FRAC  = pdro_pkg::DEF_FRAC_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [15:0]           angle,
    output logic                  busy,
    output logic signed [FRAC+1:0] cos_out,
    output logic signed [FRAC+1:0] sin_out
);
    import pdro_pkg::*;

    localparam int CW = 34;
    localparam int IW = $clog2(STEPS);
    localparam int SH = 30 - FRAC;

    logic                 busy_reg;
    logic                 flip_reg;
    logic [IW-1:0]        cnt_reg;
    logic signed [CW-1:0] x_reg, y_reg, z_reg;
    logic signed [CW-1:0] xs, ys, at;
    logic                 fold;
    logic [15:0]          ang_f;
    logic signed [CW-1:0] rx, ry;

    // Fold angle into the right half plane
    assign fold  = (angle > 16'h4000) && (angle < 16'hC000);
    assign ang_f = fold ? (angle ^ 16'h8000) : angle;

    // One micro-rotation per cycle
    assign xs = x_reg >>> cnt_reg;
    assign ys = y_reg >>> cnt_reg;
    assign at = $signed({2'b00, atan_turn(5'(cnt_reg))});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            flip_reg <= fold;
            x_reg    <= CORDIC_GAIN;
            y_reg    <= '0;
            z_reg    <= CW'($signed({ang_f, 16'h0000}));
        end
        else if (busy_reg)
        begin
            if (!z_reg[CW-1])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
            if (cnt_reg == IW'(STEPS - 1))
                busy_reg <= 1'b0;
            else
                cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // Round half up to output precision, undo fold
    assign rx = (x_reg + (CW'(1) <<< (SH - 1))) >>> SH;
    assign ry = (y_reg + (CW'(1) <<< (SH - 1))) >>> SH;
    assign cos_out = flip_reg ? -rx[FRAC+1:0] : rx[FRAC+1:0];
    assign sin_out = flip_reg ? -ry[FRAC+1:0] : ry[FRAC+1:0];
    assign busy    = busy_reg;

endmodule

@@ design/pdro_smul.sv @@
// Bit-serial signed shift-add multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps
module pdro_smul #(
    parameter int AW = 33,
    parameter int BW = 21
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [AW-1:0]    a,
    input  logic signed [BW-1:0]    b,
    output logic                    busy,
    output logic signed [AW+BW-1:0] p
);
    localparam int PW = AW + BW;
    localparam int NW = $clog2(BW);

    logic                 busy_reg;
    logic [NW-1:0]        cnt_reg;
    logic signed [PW-1:0] acc_reg, as_reg;
    logic [BW-1:0]        b_reg;
    logic signed [PW-1:0] term;

    assign term = b_reg[0] ? as_reg : '0;

    // Sign bit of the multiplier carries negative weight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            acc_reg  <= '0;
            as_reg   <= PW'(a);
            b_reg    <= b;
        end
        else if (busy_reg)
        begin
            as_reg <= as_reg <<< 1;
            b_reg  <= b_reg >> 1;
            if (cnt_reg == NW'(BW - 1))
            begin
                acc_reg  <= acc_reg - term;
                busy_reg <= 1'b0;
            end
            else
            begin
                acc_reg <= acc_reg + term;
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    assign busy = busy_reg;
    assign p    = acc_reg;

endmodule

@@ design/planar_dead_reckoning_odometry_core.sv @@
// Top level of the planar dead-reckoning odometry core
//
// Channel  Handshake             Payload
// in       in_valid / in_ready   operation, total_distance, raw_heading,
//                                yaw_rate_in, elapsed_us
// out      out_valid / out_ready pos_x, pos_y, heading, vel_x, vel_y, yaw_rate_out
//
// Reset items and the first motion item finish in the transfer cycle with no result.
// Other motion items run the CORDIC and the 1e6 multiply, then the 53-step divider beside the
// position multiplies, then the velocity multiplies (multiplier width MB = max(FRAC_BITS+2, 21)),
// then the load into the result register; the next item is taken in the cycle after the load.
// Zero elapsed time skips the divider and velocity multiplies.
// A waiting result stalls only the load of the next one; reset is async, active low.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module planar_dead_reckoning_odometry_core #(
    parameter int CORDIC_STEPS = pdro_pkg::DEF_CORDIC_STEPS,
    parameter int FRAC_BITS    = pdro_pkg::DEF_FRAC_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               operation,
    input  logic signed [31:0] total_distance,
    input  logic signed [15:0] raw_heading,
    input  logic signed [15:0] yaw_rate_in,
    input  logic [23:0]        elapsed_us,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [15:0] heading,
    output logic signed [31:0] vel_x,
    output logic signed [31:0] vel_y,
    output logic signed [15:0] yaw_rate_out
);
    import pdro_pkg::*;

    localparam int OW = FRAC_BITS + 2;
    localparam int BW = (OW > 21) ? OW : 21;
    localparam int AW = 33;
    localparam int PW = AW + BW;
    localparam int NW = 53;

    typedef enum logic [2:0] {S_IDLE, S_PH1, S_PH2, S_PH3, S_FIN} state_t;

    state_t               state_reg;
    logic                 started_reg;
    logic [15:0]          base_reg, cur_reg;
    logic signed [31:0]   prev_reg;
    logic signed [32:0]   delta_reg;
    logic signed [31:0]   acc_x_reg, acc_y_reg, hvx_reg, hvy_reg;
    logic signed [15:0]   yaw_reg;
    logic [23:0]          elap_reg;
    logic                 out_valid_reg;

    logic                 div_busy_reg, neg_reg;
    logic [5:0]           div_cnt_reg;
    logic [23:0]          rem_reg;
    logic [NW-1:0]        quo_reg;

    logic                 in_xfer, motion_go, ph1_done, ph2_done, ph3_done, elap_nz;
    logic                 out_load;
    logic [15:0]          cur_next;
    logic signed [32:0]   delta_next;
    logic                 cor_busy, m0_busy, m1_busy;
    logic signed [OW-1:0] cos_v, sin_v;
    logic signed [PW-1:0] p0, p1;
    logic                 m0_start, m1_start;
    logic signed [AW-1:0] m_a;
    logic signed [BW-1:0] m0_b, m1_b;
    logic [PW-1:0]        p0_mag;
    logic [24:0]          trial;
    logic                 trial_ok;
    logic signed [31:0]   speed_next;

    function automatic logic signed [31:0] rnd_add(input logic signed [PW-1:0] p,
                                                   input logic signed [31:0] base);
        logic signed [63:0] w;
        w = 64'(p) + (64'sd1 <<< (FRAC_BITS - 1));
        w = w >>> FRAC_BITS;
        w = w + 64'(base);
        return sat32(w);
    endfunction

    // Handshake and phase completion
    assign in_ready   = (state_reg == S_IDLE);
    assign in_xfer    = in_valid && in_ready;
    assign motion_go  = in_xfer && (operation == OP_MOTION) && started_reg;
    assign cur_next   = raw_heading - base_reg;
    assign delta_next = 33'(total_distance) - 33'(prev_reg);
    assign elap_nz    = (elap_reg != 24'd0);
    assign ph1_done   = (state_reg == S_PH1) && !cor_busy && !m0_busy;
    assign ph2_done   = (state_reg == S_PH2) && !m0_busy && !m1_busy && !div_busy_reg;
    assign ph3_done   = (state_reg == S_PH3) && !m0_busy && !m1_busy;
    assign out_load   = (state_reg == S_FIN) && (!out_valid_reg || out_ready);

    // Multiplier operand selection by phase
    assign m0_start = motion_go || ph1_done || (ph2_done && elap_nz);
    assign m1_start = ph1_done || (ph2_done && elap_nz);
    always_comb
    begin
        case (state_reg)
            S_IDLE:
            begin
                m_a  = delta_next;
                m0_b = BW'($signed({1'b0, MEGA}));
            end
            S_PH1:
            begin
                m_a  = delta_reg;
                m0_b = BW'(cos_v);
            end
            default:
            begin
                m_a  = AW'(speed_next);
                m0_b = BW'(cos_v);
            end
        endcase
        m1_b = BW'(sin_v);
    end

    pdro_cordic #(.STEPS(CORDIC_STEPS), .FRAC(FRAC_BITS)) u_cordic (
        .clk(clk), .rst_n(rst_n), .start(motion_go), .angle(cur_next),
        .busy(cor_busy), .cos_out(cos_v), .sin_out(sin_v)
    );

    pdro_smul #(.AW(AW), .BW(BW)) u_mul0 (
        .clk(clk), .rst_n(rst_n), .start(m0_start), .a(m_a), .b(m0_b),
        .busy(m0_busy), .p(p0)
    );

    pdro_smul #(.AW(AW), .BW(BW)) u_mul1 (
        .clk(clk), .rst_n(rst_n), .start(m1_start), .a(m_a), .b(m1_b),
        .busy(m1_busy), .p(p1)
    );

    // Divider step and quotient saturation
    assign p0_mag   = p0[PW-1] ? PW'(-p0) : PW'(p0);
    assign trial    = {rem_reg, quo_reg[NW-1]} - {1'b0, elap_reg};
    assign trial_ok = !trial[24];
    always_comb
    begin
        if (!neg_reg)
            speed_next = (quo_reg > NW'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF : quo_reg[31:0];
        else
            speed_next = (quo_reg > NW'(33'h080000000)) ? 32'sh80000000
                                                        : -quo_reg[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            started_reg   <= 1'b0;
            base_reg      <= '0;
            cur_reg       <= '0;
            prev_reg      <= '0;
            acc_x_reg     <= '0;
            acc_y_reg     <= '0;
            hvx_reg       <= '0;
            hvy_reg       <= '0;
            out_valid_reg <= 1'b0;
            div_busy_reg  <= 1'b0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            // Result register: load from S_FIN, clear on transfer
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            // Restoring divider, one quotient bit per cycle
            if (div_busy_reg)
            begin
                rem_reg <= trial_ok ? trial[23:0] : {rem_reg[22:0], quo_reg[NW-1]};
                quo_reg <= {quo_reg[NW-2:0], trial_ok};
                if (div_cnt_reg == 6'(NW - 1))
                    div_busy_reg <= 1'b0;
                else
                    div_cnt_reg <= div_cnt_reg + 1'b1;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer && operation == OP_RESET)
                    begin
                        base_reg  <= cur_reg + base_reg;
                        acc_x_reg <= '0;
                        acc_y_reg <= '0;
                    end
                    else if (in_xfer)
                    begin
                        cur_reg  <= cur_next;
                        prev_reg <= total_distance;
                        if (!started_reg)
                        begin
                            base_reg    <= cur_next;
                            started_reg <= 1'b1;
                        end
                        else
                        begin
                            delta_reg <= delta_next;
                            yaw_reg   <= yaw_rate_in;
                            elap_reg  <= elapsed_us;
                            state_reg <= S_PH1;
                        end
                    end
                end
                S_PH1:
                begin
                    if (ph1_done)
                    begin
                        neg_reg      <= p0[PW-1];
                        quo_reg      <= p0_mag[NW-1:0];
                        rem_reg      <= '0;
                        div_cnt_reg  <= '0;
                        div_busy_reg <= elap_nz;
                        state_reg    <= S_PH2;
                    end
                end
                S_PH2:
                begin
                    if (ph2_done)
                    begin
                        acc_x_reg <= rnd_add(p0, acc_x_reg);
                        acc_y_reg <= rnd_add(p1, acc_y_reg);
                        state_reg <= elap_nz ? S_PH3 : S_FIN;
                    end
                end
                S_PH3:
                begin
                    if (ph3_done)
                    begin
                        hvx_reg   <= rnd_add(p0, 32'sd0);
                        hvy_reg   <= rnd_add(p1, 32'sd0);
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (out_load)
                    begin
                        pos_x         <= acc_x_reg;
                        pos_y         <= acc_y_reg;
                        heading       <= cur_reg;
                        vel_x         <= hvx_reg;
                        vel_y         <= hvy_reg;
                        yaw_rate_out  <= yaw_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;

    // Checks
    `PDRO_ASSERT_IMPL(a_idle_units, in_ready, !cor_busy && !div_busy_reg)
    `PDRO_ASSERT_IMPL(a_div_phase, div_busy_reg, state_reg == S_PH2)
    `PDRO_ASSERT_IMPL(a_out_from_fin, $rose(out_valid_reg), $past(state_reg) == S_FIN)

endmodule
